// ===== src/mm4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared sizes, derived widths and types of the 4x4 fixed-point multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  // matrix size and element width
  localparam int DIM      = 4;
  localparam int ELEM_W   = 16;

  // fixed field widths of the channels
  localparam int IN_IDX_W = 4;
  localparam int IN_VAL_W = 16;
  localparam int RC_W     = 2;
  localparam int VAL_W    = 34;

  // derived sizes
  localparam int CELLS    = DIM * DIM;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int IDX_W    = $clog2(DIM);
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int SUM_W    = PROD_W + $clog2(DIM);
  localparam int ACC_W    = (SUM_W > VAL_W) ? SUM_W : VAL_W;

  // operand selector
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  // control that travels with each pair of operands into the mac
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mm4_tag_t;

endpackage

// ===== src/mm4_if.sv =====
// ----------------------------------------------------------------------------
// mm4 channel interfaces
// Valid/ready channels for element loads and for product elements.
// ----------------------------------------------------------------------------
interface mm4_in_if
  import mm4_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       which_matrix;
  logic [IN_IDX_W-1:0]        elem_index;
  logic signed [IN_VAL_W-1:0] elem_value;
  logic                       compute_now;

  modport source (output valid, which_matrix, elem_index, elem_value, compute_now,
                  input ready);
  modport sink   (input valid, which_matrix, elem_index, elem_value, compute_now,
                  output ready);
endinterface

interface mm4_out_if
  import mm4_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [RC_W-1:0]         out_row;
  logic [RC_W-1:0]         out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

// ===== src/mm4_store.sv =====
// ----------------------------------------------------------------------------
// mm4_store
// One operand matrix: synchronous memory with one write and one read port,
// registered read data, per-entry valid bits so that reset reads as zero.
// ----------------------------------------------------------------------------
module mm4_store
  import mm4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ELEM_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ELEM_W-1:0] rd_data
);

  logic [ELEM_W-1:0] mem [CELLS];
  logic [CELLS-1:0]  vld_r;
  logic [ELEM_W-1:0] data_r;
  logic              hit_r;

  // memory array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_r <= mem[rd_addr];
  end

  // written-entry flags and read hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      hit_r <= vld_r[rd_addr];
    end
  end

  // never-written entries read as zero
  assign rd_data = hit_r ? data_r : '0;

endmodule

// ===== src/mm4_mac.sv =====
// ----------------------------------------------------------------------------
// mm4_mac
// Two-stage multiply-accumulate: registered product, then running sum that
// restarts on the first pair of a dot product and flags the last one.
// ----------------------------------------------------------------------------
module mm4_mac
  import mm4_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mm4_tag_t                tag,
  input  logic signed [ELEM_W-1:0] a,
  input  logic signed [ELEM_W-1:0] b,
  output logic                    done,
  output logic signed [VAL_W-1:0] sum
);

  logic signed [PROD_W-1:0] prod_r;
  mm4_tag_t                 tag_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     done_r;

  // product stage
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  // accumulate, restart on the first pair
  always_comb begin
    if (tag_r.first) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      done_r <= 1'b0;
    end else begin
      tag_r  <= tag;
      done_r <= tag_r.vld & tag_r.last;
    end
  end

  assign done = done_r;
  assign sum  = acc_r[VAL_W-1:0];

endmodule

// ===== src/matrix4x4_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Loads Q8.8 elements into left and right operand memories and, on request,
// streams the Q18.16 product matrix in row-major order.
//
//   channel  dir  payload                                       handshake
//   in_ch    in   which_matrix, elem_index, elem_value,         valid/ready
//                 compute_now
//   out_ch   out  out_row, out_col, out_value, out_last         valid/ready
//
// A load item is taken while the block is idle. A compute item then holds off
// the input until the last product element is in the output register; each
// product element takes 4 memory reads, 2 mac stages, load of the output
// register and one taken result; the single read port of each operand memory sets the read phase.
// Reset is synchronous; the operand memories read as zero until written.
// A stalled sink holds the product element and halts the next element's reads.
// ----------------------------------------------------------------------------
module matrix4x4_multiply
  import mm4_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mm4_in_if.sink    in_ch,
  mm4_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    row_r;
  logic [IDX_W-1:0]    col_r;
  logic [IDX_W-1:0]    k_r;
  mm4_tag_t            tag_r;

  logic                out_valid_r;
  logic [RC_W-1:0]     out_row_r;
  logic [RC_W-1:0]     out_col_r;
  logic [VAL_W-1:0]    out_value_r;
  logic                out_last_r;

  logic                in_take;
  logic                wr_ok;
  logic                wr_left;
  logic                wr_right;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ELEM_W-1:0]   wr_data;
  logic [ADDR_W-1:0]   rd_addr_left;
  logic [ADDR_W-1:0]   rd_addr_right;
  logic [ELEM_W-1:0]   rd_left;
  logic [ELEM_W-1:0]   rd_right;
  logic                issue;
  logic                k_end;
  logic                col_end;
  logic                row_end;
  logic                mac_done;
  logic signed [VAL_W-1:0] mac_sum;

  // input handshake and store write
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid & in_ch.ready;
  assign wr_ok       = int'(in_ch.elem_index) < CELLS;
  assign wr_addr     = ADDR_W'(in_ch.elem_index);
  assign wr_data     = ELEM_W'(in_ch.elem_value);
  assign wr_left     = in_take & wr_ok & (in_ch.which_matrix == SEL_LEFT);
  assign wr_right    = in_take & wr_ok & (in_ch.which_matrix == SEL_RIGHT);

  // read addresses: left row r, right column c, step k
  assign rd_addr_left  = ADDR_W'(row_r) * ADDR_W'(DIM) + ADDR_W'(k_r);
  assign rd_addr_right = ADDR_W'(k_r) * ADDR_W'(DIM) + ADDR_W'(col_r);

  // sequencing conditions
  assign issue   = (state_r == ST_ISSUE) & ~out_valid_r;
  assign k_end   = (k_r == IDX_W'(DIM - 1));
  assign col_end = (col_r == IDX_W'(DIM - 1));
  assign row_end = (row_r == IDX_W'(DIM - 1));

  mm4_store u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_left),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_left),
    .rd_data (rd_left)
  );

  mm4_store u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_right),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_right),
    .rd_data (rd_right)
  );

  mm4_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .tag   (tag_r),
    .a     (rd_left),
    .b     (rd_right),
    .done  (mac_done),
    .sum   (mac_sum)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // tag aligned with the registered memory read
      tag_r.vld   <= issue;
      tag_r.first <= (k_r == '0);
      tag_r.last  <= k_end;

      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_take && in_ch.compute_now) begin
            row_r   <= '0;
            col_r   <= '0;
            k_r     <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (issue) begin
            if (k_end) begin
              k_r     <= '0;
              state_r <= ST_DRAIN;
            end else begin
              k_r <= k_r + IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            out_valid_r <= 1'b1;
            out_row_r   <= RC_W'(row_r);
            out_col_r   <= RC_W'(col_r);
            out_value_r <= mac_sum;
            out_last_r  <= row_end & col_end;
            if (col_end) begin
              col_r <= '0;
              row_r <= row_r + IDX_W'(1);
            end else begin
              col_r <= col_r + IDX_W'(1);
            end
            state_r <= (row_end && col_end) ? ST_IDLE : ST_ISSUE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_last  = out_last_r;

endmodule

// ===== verif/matrix4x4_multiply_test.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_test
// Self-checking bench for the 4x4 Q8.8 matrix multiplier. Element loads are
// driven from a queue, and the bench keeps its own copy of both operand stores.
// Each compute item makes it queue the sixteen Q18.16 product elements it
// expects. Each product element the block emits is checked against the oldest
// queued one. Random gaps on the load side and random stalls on the product
// side vary the timing.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_test
  import mm4_pkg::*;
();

  // element values at the edges of Q8.8
  localparam logic signed [IN_VAL_W-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [IN_VAL_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [IN_VAL_W-1:0] Q_ONE = 16'sh0100;
  localparam logic signed [IN_VAL_W-1:0] Q_NEG = 16'shFFFF;
  localparam int RANDOM_LOADS = 350;
  localparam int MAX_WAIT     = 17;

  typedef struct {
    logic                       which;
    logic [IN_IDX_W-1:0]        index;
    logic signed [IN_VAL_W-1:0] value;
    logic                       compute;
    bit                         drain_first;  // hold until all products are in
  } elem_load_t;

  typedef struct {
    logic [RC_W-1:0]         row;
    logic [RC_W-1:0]         col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } product_elem_t;

  logic clk = 1'b0;
  logic rst_n;

  mm4_in_if  in_ch ();
  mm4_out_if out_ch ();

  matrix4x4_multiply dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // bench copy of the operand stores
  logic signed [ELEM_W-1:0] left_mat  [CELLS];
  logic signed [ELEM_W-1:0] right_mat [CELLS];

  elem_load_t    load_q[$];     // loads not yet presented
  product_elem_t product_q[$];  // product elements still owed by the block

  int total_loads   = 0;
  int loads_issued  = 0;
  int loads_taken   = 0;
  int results_seen  = 0;
  int matrices_done = 0;
  int err_count     = 0;
  int send_wait     = 0;
  int stall_left    = 0;
  int ready_mark    = 0;
  bit in_calm       = 1'b0;
  bit out_calm      = 1'b0;

  always #5 clk = ~clk;

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic add_load(input logic sel, input int idx, input logic signed [IN_VAL_W-1:0] val,
                          input logic go, input bit drain = 1'b0);
    elem_load_t ld;
    ld.which       = sel;
    ld.index       = IN_IDX_W'(idx);
    ld.value       = val;
    ld.compute     = go;
    ld.drain_first = drain;
    load_q.push_back(ld);
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // write one element and, on a compute item, queue the whole product matrix
  task automatic apply_load(input logic sel, input logic [IN_IDX_W-1:0] idx,
                            input logic signed [IN_VAL_W-1:0] val, input logic go);
    product_elem_t            p;
    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W-1:0]  acc;
    if (idx < CELLS) begin
      if (sel == SEL_RIGHT) right_mat[idx] = val;
      else left_mat[idx] = val;
    end
    if (go) begin
      matrices_done++;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++) begin
            prod = PROD_W'(left_mat[r*DIM + k]) * PROD_W'(right_mat[k*DIM + c]);
            acc  = acc + VAL_W'(prod);
          end
          p.row   = RC_W'(r);
          p.col   = RC_W'(c);
          p.value = acc;
          p.last  = (r == DIM-1) && (c == DIM-1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  // load driver: one item at a time, random gap after each accepted item
  always @(negedge clk) begin : load_drive
    elem_load_t nxt;
    logic       vld_next;
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.which_matrix <= SEL_LEFT;
      in_ch.elem_index   <= '0;
      in_ch.elem_value   <= '0;
      in_ch.compute_now  <= 1'b0;
    end else begin
      vld_next = in_ch.valid;
      if (in_ch.valid && loads_taken == loads_issued) begin
        vld_next = 1'b0;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        send_wait = draw_wait(in_calm);
      end
      if (!vld_next) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (load_q.size() != 0 &&
                     !(load_q[0].drain_first && product_q.size() != 0)) begin
          nxt = load_q.pop_front();
          in_ch.which_matrix <= nxt.which;
          in_ch.elem_index   <= nxt.index;
          in_ch.elem_value   <= nxt.value;
          in_ch.compute_now  <= nxt.compute;
          vld_next = 1'b1;
          loads_issued++;
        end
      end
      in_ch.valid <= vld_next;
    end
  end

  // product side ready: random stall after each taken item
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (results_seen != ready_mark) begin
        ready_mark = results_seen;
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        stall_left = draw_wait(out_calm);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted loads, check each taken product element
  always @(posedge clk) begin : watch
    product_elem_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        apply_load(in_ch.which_matrix, in_ch.elem_index, in_ch.elem_value, in_ch.compute_now);
        loads_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (product_q.size() == 0) begin
          note_error($sformatf("unexpected product element: row %0d col %0d value %0d last %0b",
                               out_ch.out_row, out_ch.out_col, out_ch.out_value,
                               out_ch.out_last));
        end else begin
          want = product_q.pop_front();
          if (out_ch.out_row !== want.row || out_ch.out_col !== want.col ||
              out_ch.out_value !== want.value || out_ch.out_last !== want.last)
            note_error($sformatf({"product element %0d: expected row %0d col %0d value %0d ",
                                  "last %0b, got row %0d col %0d value %0d last %0b"},
                                 results_seen, want.row, want.col, want.value, want.last,
                                 out_ch.out_row, out_ch.out_col, out_ch.out_value,
                                 out_ch.out_last));
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : main
    int                         n;
    int                         grp;
    bit                         well;
    logic signed [IN_VAL_W-1:0] val;
    rst_n = 1'b0;
    foreach (left_mat[i]) begin
      left_mat[i]  = '0;
      right_mat[i] = '0;
    end

    // product of the cleared stores
    add_load(SEL_LEFT, 0, '0, 1'b1);
    // most positive sum: row and column of most negative elements
    for (int k = 0; k < DIM; k++) add_load(SEL_LEFT, k, Q_MIN, 1'b0);
    for (int k = 0; k < DIM; k++) add_load(SEL_RIGHT, k*DIM, Q_MIN, k == DIM-1);
    // most negative sum
    for (int k = 0; k < DIM; k++) add_load(SEL_RIGHT, k*DIM, Q_MAX, k == DIM-1);
    // compute on a left write, after the block has drained
    add_load(SEL_LEFT, CELLS-1, Q_MAX, 1'b0, 1'b1);
    add_load(SEL_RIGHT, CELLS-1, Q_NEG, 1'b0);
    add_load(SEL_LEFT, 5, Q_ONE, 1'b1);
    // compute on a right write at the top index
    add_load(SEL_RIGHT, CELLS-1, Q_MIN, 1'b1);

    // random groups: mostly runs of writes closed by a compute, some bare writes
    n = 0;
    while (n < RANDOM_LOADS) begin
      grp  = $urandom_range(1, 20);
      well = ($urandom_range(0, 6) != 0);
      for (int i = 0; i < grp; i++) begin
        case ($urandom_range(0, 7))
          0:       val = Q_MIN;
          1:       val = Q_MAX;
          2:       val = '0;
          default: val = IN_VAL_W'($urandom);
        endcase
        add_load(1'($urandom_range(0, 1)), $urandom_range(0, CELLS-1), val,
                 well && (i == grp-1), (i == 0) && ($urandom_range(0, 5) == 0));
        n++;
      end
    end
    total_loads = load_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (loads_taken < total_loads || product_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("covered %0d element loads and %0d product matrices (%0d elements checked)",
             loads_taken, matrices_done, results_seen);
    $display("mismatches and unexpected elements: %0d", err_count);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d loads taken and %0d product elements owed",
             loads_taken, product_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
